[rtl/core/esc_drive_brake_reverse_sequencer_assert.svh]
// Assertion helpers for the sequencer. Both sample on clk and are
// disabled while rst is high.
`ifndef ESC_DRIVE_BRAKE_REVERSE_SEQUENCER_ASSERT_SVH
`define ESC_DRIVE_BRAKE_REVERSE_SEQUENCER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/esc_dbrs_pkg.sv]
package esc_dbrs_pkg;

  // Configuration register indexes
  localparam logic [3:0] REG_SERVO_NEUTRAL = 4'd0;
  localparam logic [3:0] REG_SERVO_LEFT    = 4'd1;
  localparam logic [3:0] REG_SERVO_RIGHT   = 4'd2;
  localparam logic [3:0] REG_ESC_NEUTRAL   = 4'd3;
  localparam logic [3:0] REG_ESC_BRAKE     = 4'd4;
  localparam logic [3:0] REG_ESC_FWD_THR   = 4'd5;
  localparam logic [3:0] REG_ESC_FWD_MAX   = 4'd6;
  localparam logic [3:0] REG_ESC_REV_MAX   = 4'd7;

  // Register reset values
  localparam logic [11:0] RST_SERVO_NEUTRAL = 12'd1500;
  localparam logic [11:0] RST_SERVO_LEFT    = 12'd1100;
  localparam logic [11:0] RST_SERVO_RIGHT   = 12'd1900;
  localparam logic [15:0] RST_ESC_NEUTRAL   = 16'd15000;
  localparam logic [15:0] RST_ESC_BRAKE     = 16'd10000;
  localparam logic [15:0] RST_ESC_FWD_THR   = 16'd14000;
  localparam logic [15:0] RST_ESC_FWD_MAX   = 16'd10000;
  localparam logic [15:0] RST_ESC_REV_MAX   = 16'd20000;

  // Parameter defaults
  localparam int DEF_CMD_LIMIT               = 64;
  localparam int DEF_ESC_REV_THRESHOLD       = 16000;
  localparam int DEF_ESC_TO_REVERSE_PULSE    = 10000;
  localparam int DEF_WAIT_NEUTRAL_TO_REVERSE = 10;
  localparam int DEF_WAIT_TO_BRAKE           = 10;
  localparam int DEF_WAIT_DRIVE_TO_REVERSE   = 10;

  // Signed divide by 64, truncated toward zero
  function automatic logic signed [10:0] div64(input logic signed [16:0] d);
    logic signed [16:0] adj;
    adj = d[16] ? (d + 17'sd63) : d;
    return 11'(adj >>> 6);
  endfunction

endpackage

[rtl/core/esc_drive_brake_reverse_sequencer.sv]
// Steering servo and throttle (ESC) drive / brake / reverse sequencer.
// Input channel (in_valid / in_ready) carries one control tick: angle_cmd,
// speed_cmd and brake_cmd. Output channel (out_valid / out_ready) returns
// exactly one result transaction per tick: servo_pulse, esc_update,
// esc_pulse (zero when esc_update is low) and mode.
// Angle and speed are latched only within +/-CMD_LIMIT; brake is always taken.
// Latency: result is presented the cycle after the input transaction.
// Throughput: one transaction per cycle while out_ready is high. All
// arithmetic (two narrow multiplies, sum and clamp) sits between the
// held state and the result register, so nothing iterates.
// Stall: in_ready drops only while a result is held and out_ready is low;
// the held result stays put until taken, and the next tick is accepted in
// the same cycle the held one leaves.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; indexes beyond 7 are ignored. Write it only while the block is idle.
// Reset (rst, synchronous): registers return to defaults, mode to neutral,
// wait counter, last brake and held commands to zero, output empty.
module esc_drive_brake_reverse_sequencer #(
  parameter int CMD_LIMIT               = esc_dbrs_pkg::DEF_CMD_LIMIT,
  parameter int ESC_REV_THRESHOLD       = esc_dbrs_pkg::DEF_ESC_REV_THRESHOLD,
  parameter int ESC_TO_REVERSE_PULSE    = esc_dbrs_pkg::DEF_ESC_TO_REVERSE_PULSE,
  parameter int WAIT_NEUTRAL_TO_REVERSE = esc_dbrs_pkg::DEF_WAIT_NEUTRAL_TO_REVERSE,
  parameter int WAIT_TO_BRAKE           = esc_dbrs_pkg::DEF_WAIT_TO_BRAKE,
  parameter int WAIT_DRIVE_TO_REVERSE   = esc_dbrs_pkg::DEF_WAIT_DRIVE_TO_REVERSE
) (
  input  logic              clk,
  input  logic              rst,
  // input transaction
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] angle_cmd,
  input  logic signed [7:0] speed_cmd,
  input  logic              brake_cmd,
  // result transaction
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       servo_pulse,
  output logic              esc_update,
  output logic [15:0]       esc_pulse,
  output logic [2:0]        mode,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  typedef enum logic [2:0] {
    MODE_DRIVE    = 3'd0,
    MODE_REVERSE  = 3'd1,
    MODE_DNEUTRAL = 3'd2,
    MODE_NEUTRAL  = 3'd3,
    MODE_D2R      = 3'd4,
    MODE_D2B      = 3'd5,
    MODE_R2B      = 3'd6
  } mode_t;

  localparam logic signed [8:0]  LIMIT_POS   = 9'(CMD_LIMIT);
  localparam logic signed [8:0]  LIMIT_NEG   = -LIMIT_POS;
  localparam logic [15:0]        REV_THR     = 16'(ESC_REV_THRESHOLD);
  localparam logic [15:0]        TO_REV_PULSE = 16'(ESC_TO_REVERSE_PULSE);
  localparam logic [7:0]         WAIT_NR     = 8'(WAIT_NEUTRAL_TO_REVERSE);
  localparam logic [7:0]         WAIT_BRK    = 8'(WAIT_TO_BRAKE);
  localparam logic [7:0]         WAIT_DR     = 8'(WAIT_DRIVE_TO_REVERSE);

  // configuration registers
  logic [11:0] servo_neutral_us, servo_left_end_us, servo_right_end_us;
  logic [15:0] esc_neutral_pulse, esc_brake_pulse, esc_fwd_threshold;
  logic [15:0] esc_fwd_max, esc_rev_max;

  // sequencer state
  mode_t              drive_mode, drive_mode_next;
  logic [7:0]         wait_count, wait_count_next;
  logic               last_brake, last_brake_next;
  logic signed [7:0]  held_angle, held_angle_next;
  logic signed [7:0]  held_speed, held_speed_next;

  logic               in_xfer;
  logic               upd_next;
  logic [11:0]        servo_next;
  logic [15:0]        esc_next;

  // datapath
  logic signed [8:0]  angle_ext, speed_ext;
  logic signed [8:0]  angle_mag;
  logic signed [7:0]  servo_step;
  logic signed [16:0] servo_prod;
  logic signed [17:0] servo_sum;
  logic signed [16:0] esc_diff;
  logic signed [10:0] esc_step;
  logic signed [8:0]  speed_neg;
  logic signed [19:0] esc_prod;
  logic signed [20:0] esc_base;
  logic signed [20:0] esc_sum;
  logic signed [20:0] esc_raw;

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign mode      = drive_mode;

  // command latch, limit check
  always_comb begin
    angle_ext = {angle_cmd[7], angle_cmd};
    speed_ext = {speed_cmd[7], speed_cmd};
    held_angle_next = (angle_ext <= LIMIT_POS && angle_ext >= LIMIT_NEG) ?
                      angle_cmd : held_angle;
    held_speed_next = (speed_ext <= LIMIT_POS && speed_ext >= LIMIT_NEG) ?
                      speed_cmd : held_speed;
  end

  // servo: neutral + step * |angle|; step taken toward the end stop
  always_comb begin
    if (!held_angle_next[7]) begin
      servo_step = 8'(esc_dbrs_pkg::div64(17'($signed({1'b0, servo_left_end_us}))
                                          - 17'($signed({1'b0, servo_neutral_us}))));
      angle_mag  = {held_angle_next[7], held_angle_next};
    end else begin
      servo_step = 8'(esc_dbrs_pkg::div64(17'($signed({1'b0, servo_right_end_us}))
                                          - 17'($signed({1'b0, servo_neutral_us}))));
      angle_mag  = -{held_angle_next[7], held_angle_next};
    end
    servo_prod = 17'(servo_step * angle_mag);
    servo_sum  = 18'($signed({1'b0, servo_neutral_us})) + 18'(servo_prod);
    if (servo_sum < 0)
      servo_next = '0;
    else if (servo_sum > 18'sd4095)
      servo_next = '1;
    else
      servo_next = servo_sum[11:0];
  end

  // throttle ramp: forward from threshold toward fwd_max, reverse from
  // the fixed reverse threshold toward rev_max; scaled by -speed
  always_comb begin
    if (held_speed_next > 0) begin
      esc_diff = 17'($signed({1'b0, esc_fwd_threshold})) - 17'($signed({1'b0, esc_fwd_max}));
      esc_base = 21'($signed({1'b0, esc_fwd_threshold}));
    end else begin
      esc_diff = 17'($signed({1'b0, esc_rev_max})) - 17'($signed({1'b0, REV_THR}));
      esc_base = 21'($signed({1'b0, REV_THR}));
    end
    esc_step  = esc_dbrs_pkg::div64(esc_diff);
    speed_neg = -{held_speed_next[7], held_speed_next};
    esc_prod  = 20'(esc_step * speed_neg);
    esc_sum   = esc_base + 21'(esc_prod);
  end

  // sequencer next state
  always_comb begin
    drive_mode_next = drive_mode;
    wait_count_next = wait_count;
    last_brake_next = last_brake;
    upd_next        = 1'b0;
    esc_raw         = '0;

    if (wait_count != '0) begin
      wait_count_next = wait_count - 8'd1;
      if (wait_count == 8'd1) begin
        if (drive_mode == MODE_R2B) begin
          upd_next = 1'b1;
          esc_raw  = 21'($signed({1'b0, esc_brake_pulse}));
        end else if (drive_mode == MODE_D2R) begin
          drive_mode_next = MODE_REVERSE;
          wait_count_next = WAIT_NR;
          upd_next        = 1'b1;
          esc_raw         = 21'($signed({1'b0, esc_neutral_pulse}));
        end
      end
    end else if (last_brake != brake_cmd) begin
      last_brake_next = brake_cmd;
      if (!brake_cmd) begin
        if (held_speed_next < 0) begin
          drive_mode_next = MODE_REVERSE;
          wait_count_next = WAIT_NR;
          upd_next        = 1'b1;
          esc_raw         = 21'($signed({1'b0, esc_neutral_pulse}));
        end
      end else if (drive_mode == MODE_DRIVE || drive_mode == MODE_DNEUTRAL) begin
        drive_mode_next = MODE_D2B;
        upd_next        = 1'b1;
        esc_raw         = 21'($signed({1'b0, esc_brake_pulse}));
      end else if (drive_mode == MODE_REVERSE || drive_mode == MODE_NEUTRAL) begin
        drive_mode_next = MODE_R2B;
        wait_count_next = WAIT_BRK;
        upd_next        = 1'b1;
        esc_raw         = 21'($signed({1'b0, esc_fwd_threshold}));
      end
    end else if (!brake_cmd) begin
      upd_next = 1'b1;
      if (drive_mode == MODE_DNEUTRAL && held_speed_next < 0) begin
        drive_mode_next = MODE_D2R;
        wait_count_next = WAIT_DR;
        esc_raw         = 21'($signed({1'b0, TO_REV_PULSE}));
      end else if (held_speed_next > 0) begin
        drive_mode_next = MODE_DRIVE;
        esc_raw         = esc_sum;
      end else if (held_speed_next == 0) begin
        esc_raw = 21'($signed({1'b0, esc_neutral_pulse}));
        if (drive_mode == MODE_DRIVE)
          drive_mode_next = MODE_DNEUTRAL;
        else if (drive_mode != MODE_DNEUTRAL)
          drive_mode_next = MODE_NEUTRAL;
      end else begin
        drive_mode_next = MODE_REVERSE;
        esc_raw         = esc_sum;
      end
    end

    // saturate to field range; zero when no new pulse
    if (!upd_next || esc_raw < 0)
      esc_next = '0;
    else if (esc_raw > 21'sd65535)
      esc_next = '1;
    else
      esc_next = esc_raw[15:0];
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_neutral_us   <= esc_dbrs_pkg::RST_SERVO_NEUTRAL;
      servo_left_end_us  <= esc_dbrs_pkg::RST_SERVO_LEFT;
      servo_right_end_us <= esc_dbrs_pkg::RST_SERVO_RIGHT;
      esc_neutral_pulse  <= esc_dbrs_pkg::RST_ESC_NEUTRAL;
      esc_brake_pulse    <= esc_dbrs_pkg::RST_ESC_BRAKE;
      esc_fwd_threshold  <= esc_dbrs_pkg::RST_ESC_FWD_THR;
      esc_fwd_max        <= esc_dbrs_pkg::RST_ESC_FWD_MAX;
      esc_rev_max        <= esc_dbrs_pkg::RST_ESC_REV_MAX;
      drive_mode         <= MODE_NEUTRAL;
      wait_count         <= '0;
      last_brake         <= 1'b0;
      held_angle         <= '0;
      held_speed         <= '0;
      out_valid          <= 1'b0;
      servo_pulse        <= '0;
      esc_update         <= 1'b0;
      esc_pulse          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          esc_dbrs_pkg::REG_SERVO_NEUTRAL: servo_neutral_us   <= cfg_data[11:0];
          esc_dbrs_pkg::REG_SERVO_LEFT:    servo_left_end_us  <= cfg_data[11:0];
          esc_dbrs_pkg::REG_SERVO_RIGHT:   servo_right_end_us <= cfg_data[11:0];
          esc_dbrs_pkg::REG_ESC_NEUTRAL:   esc_neutral_pulse  <= cfg_data;
          esc_dbrs_pkg::REG_ESC_BRAKE:     esc_brake_pulse    <= cfg_data;
          esc_dbrs_pkg::REG_ESC_FWD_THR:   esc_fwd_threshold  <= cfg_data;
          esc_dbrs_pkg::REG_ESC_FWD_MAX:   esc_fwd_max        <= cfg_data;
          esc_dbrs_pkg::REG_ESC_REV_MAX:   esc_rev_max        <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        drive_mode  <= drive_mode_next;
        wait_count  <= wait_count_next;
        last_brake  <= last_brake_next;
        held_angle  <= held_angle_next;
        held_speed  <= held_speed_next;
        out_valid   <= 1'b1;
        servo_pulse <= servo_next;
        esc_update  <= upd_next;
        esc_pulse   <= esc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`include "esc_drive_brake_reverse_sequencer_assert.svh"

  // a running wait only exists in the reverse and transition sequences
  `ESC_ASSERT_SAME(a_wait_mode, wait_count != '0, drive_mode == MODE_REVERSE || drive_mode == MODE_D2R || drive_mode == MODE_R2B, "wait counter running in wrong mode")
  // every accepted tick yields a result next cycle
  `ESC_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after tick")
  // throttle pulse is zero unless a new one is issued
  `ESC_ASSERT_SAME(a_esc_zero, out_valid && !esc_update, esc_pulse == '0, "throttle pulse without update")

endmodule
